>>> rtl/ntrlru_pkg.sv
`default_nettype none

package ntrlru_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned ID_W     = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Packed widths, rounded up to whole bytes.
  localparam int unsigned IN_BITS  = ID_W + TIME_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = SLOT_W + ACTION_W + ID_W + COUNT_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Kind of table update reported with each result.
  typedef enum logic [ACTION_W-1:0] {
    ACT_REFRESH = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_REPLACE = 2'd2
  } action_t;

endpackage

`default_nettype wire

>>> rtl/node_table_register_lru.sv
// Neighbor table of node ids with last-seen timestamps and least-recently-seen
// replacement. Each input transaction carries a node id and the current time
// and yields exactly one result transaction: the slot that was refreshed
// (id already present), appended (free room) or replaced (table full; the
// entry with the smallest unsigned timestamp, lowest index on ties), the
// action taken, the evicted id (zero unless replaced) and the entry count
// after the update. The table sits in a single-read-port memory that a small
// sequencer scans one entry per cycle, matching the id and tracking the oldest
// entry in the same pass. An item occupies the block from acceptance, through
// the scan of the filled entries (skipped when the table is empty), until its
// decision, which also waits for as long as the output register still holds
// an untaken result; no new item is accepted meanwhile. The next item can be
// accepted while the previous result still waits on the output.
// Slot and count fields carry the low bits if TABLE_DEPTH exceeds their width.

`default_nettype none

module node_table_register_lru #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata fields from bit 0: node_id[7:0], now_time[39:8]
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [ntrlru_pkg::IN_W-1:0]   in_tdata,
  // out_tdata fields from bit 0: slot[3:0], action[5:4], evicted_id[13:6],
  // table_count[18:14], zero fill above
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [ntrlru_pkg::OUT_W-1:0]       out_tdata
);

  import ntrlru_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    fill_count_r;
  logic [ID_W-1:0]     req_id_r;
  logic [TIME_W-1:0]   req_time_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                cmp_vld_r;
  logic [ID_W-1:0]     rd_id_r;
  logic [TIME_W-1:0]   rd_time_r;
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [IDX_W-1:0]    min_idx_r;
  logic [ID_W-1:0]     min_id_r;
  logic [TIME_W-1:0]   min_time_r;
  logic                out_tvalid_r;
  logic [OUT_W-1:0]    out_tdata_r;

  // Table storage.
  logic [ID_W-1:0]     ids_mem   [TABLE_DEPTH];
  logic [TIME_W-1:0]   times_mem [TABLE_DEPTH];

  logic                in_fire;
  logic                out_free;
  logic                is_full;
  logic [CNT_W-1:0]    last_idx;
  logic                rd_last;
  logic                cmp_last;
  logic                cmp_match;
  logic                cmp_older;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic                wr_id_en;
  logic [IDX_W-1:0]    res_idx;
  action_t             res_action;
  logic [ID_W-1:0]     res_evicted;
  logic [CNT_W-1:0]    res_count;
  logic [31:0]         res_idx_ext;
  logic [31:0]         res_count_ext;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // Scan bookkeeping.
  assign is_full   = (fill_count_r == CNT_W'(TABLE_DEPTH));
  assign last_idx  = fill_count_r - CNT_W'(1);
  assign rd_last   = (CNT_W'(rd_idx_r) == last_idx);
  assign cmp_last  = cmp_vld_r && (CNT_W'(cmp_idx_r) == last_idx);
  assign cmp_match = cmp_vld_r && !hit_r && (rd_id_r == req_id_r);
  assign cmp_older = cmp_vld_r && ((cmp_idx_r == '0) || (rd_time_r < min_time_r));

  // Decision taken once the scan has finished.
  always_comb begin
    res_evicted = '0;
    res_count   = fill_count_r;
    wr_id_en    = 1'b1;
    if (hit_r) begin
      res_idx    = hit_idx_r;
      res_action = ACT_REFRESH;
      wr_id_en   = 1'b0;
    end else if (is_full) begin
      res_idx     = min_idx_r;
      res_action  = ACT_REPLACE;
      res_evicted = min_id_r;
    end else begin
      res_idx    = fill_count_r[IDX_W-1:0];
      res_action = ACT_APPEND;
      res_count  = fill_count_r + CNT_W'(1);
    end
  end

  assign res_idx_ext   = 32'(res_idx);
  assign res_count_ext = 32'(res_count);
  assign wr_en         = (state_r == ST_DECIDE) && out_free;
  assign wr_idx        = res_idx;

  // Table write at decision time and one registered read per scan cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      times_mem[wr_idx] <= req_time_r;
      if (wr_id_en) begin
        ids_mem[wr_idx] <= req_id_r;
      end
    end
    rd_id_r   <= ids_mem[rd_idx_r];
    rd_time_r <= times_mem[rd_idx_r];
  end

  // Sequencer, scan trackers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
      rd_idx_r     <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // The output register loads at decision time and empties when taken.
      if ((state_r == ST_DECIDE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cmp_vld_r <= 1'b0;
          if (in_fire) begin
            req_id_r   <= in_tdata[ID_W-1:0];
            req_time_r <= in_tdata[ID_W +: TIME_W];
            rd_idx_r   <= '0;
            hit_r      <= 1'b0;
            if (fill_count_r == '0) begin
              state_r <= ST_DECIDE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Issue the next read while the previous entry is compared.
          cmp_vld_r <= !cmp_last;
          cmp_idx_r <= rd_idx_r;
          if (!rd_last) begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
          if (cmp_match) begin
            hit_r     <= 1'b1;
            hit_idx_r <= cmp_idx_r;
          end
          if (cmp_older) begin
            min_idx_r  <= cmp_idx_r;
            min_id_r   <= rd_id_r;
            min_time_r <= rd_time_r;
          end
          if (cmp_last) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_tdata_r  <= OUT_W'({res_count_ext[COUNT_W-1:0], res_evicted,
                                    res_action, res_idx_ext[SLOT_W-1:0]});
            fill_count_r <= res_count;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
